FILE: sv/dttd_pkg.sv
// Shared types and constants of the difficulty-to-target divider.
package dttd_pkg;

  // Field and register widths
  localparam int DIFF_W      = 64;
  localparam int FRAC_W      = 52;
  localparam int EXP_W       = 11;
  localparam int SIG_W       = FRAC_W + 1;
  localparam int REF_MANT_W  = 24;
  localparam int SHIFT_W     = 8;
  localparam int MANT_IDX_W  = $clog2(REF_MANT_W);
  localparam int WORD_OUT_W  = 32;
  localparam int WIDX_W      = 3;
  localparam int CODE_W      = 2;
  localparam int MAX_WORDS   = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  // Exponent of the integer significand: value = sig * 2^(expo - EXP_BIAS_INT)
  localparam int EXP_BIAS_INT = 1075;
  localparam logic [EXP_W-1:0] EXP_ALL_ONES = '1;

  // Any clamp target fits below 2^QUOT_BITS; larger quotients only need a flag
  localparam int QUOT_BITS = REF_MANT_W + (1 << SHIFT_W);
  // Dividend positions walked by the divider, top position first
  localparam int DIV_STEPS = QUOT_BITS + SIG_W + REF_MANT_W - 1;
  localparam int DIV_TOP   = DIV_STEPS - 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  // Start index at or below this means the dividend alone exceeds the window
  localparam int BIG_IDX_MAX = REF_MANT_W - 2;
  // Signed index of the reference mantissa bit fed into the divider
  localparam int IDX_W = 12;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REF_MANT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_SHIFT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MANT  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SHIFT = 8'd3;

  // Register reset values
  localparam logic [REF_MANT_W-1:0] REF_MANT_RST  = 24'h0fffff;
  localparam logic [SHIFT_W-1:0]    REF_SHIFT_RST = 8'd208;
  localparam logic [REF_MANT_W-1:0] MAX_MANT_RST  = 24'h0fffff;
  localparam logic [SHIFT_W-1:0]    MAX_SHIFT_RST = 8'd224;

  typedef enum logic [CODE_W-1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_MAX   = 2'd1,
    CLAMP_ONE   = 2'd2,
    CLAMP_INPUT = 2'd3
  } clamp_code_t;

  typedef enum logic [1:0] {
    KIND_FINITE = 2'd0,
    KIND_INF    = 2'd1,
    KIND_INPUT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_DIVIDE  = 2'd1,
    ST_RESOLVE = 2'd2,
    ST_FINISH  = 2'd3
  } state_t;

  typedef struct packed {
    logic [REF_MANT_W-1:0] ref_mant;
    logic [SHIFT_W-1:0]    ref_shift;
    logic [REF_MANT_W-1:0] max_mant;
    logic [SHIFT_W-1:0]    max_shift;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hi_pos;
    logic resolve;
    logic finish;
    logic shift_out;
  } cmd_t;

endpackage

FILE: sv/difficulty_to_target_divider_core.sv
// Top level of the difficulty-to-target divider.
// Takes a difficulty as the raw bits of an IEEE binary64 number and returns the
// target floor((ref_mantissa << ref_shift) / difficulty), exact, clamped down to
// max_mantissa << max_shift, raised to 1 when zero and saturated to all ones at
// TARGET_BITS. The target leaves as up to eight words of WORD_BITS, least
// significant first, each zero-extended or cut to 32 bits in out_tdata; tuser
// carries the word position and the clamp code, which is the same on every word.
// An item is taken and decoded in the idle state, then a one-bit-per-cycle
// restoring divider runs over a 53-bit significand; the quotient is then clamped
// and loaded into the output register. The words of one target stream out while
// the next difficulty is being divided; a new target waits in the divider only
// if the previous one has not been fully taken. Registers must be written through
// the cfg port only while no item is in flight; the block does not enforce this.
module difficulty_to_target_divider_core #(
  parameter int TARGET_BITS = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dttd_pkg::DIFF_W-1:0]         in_tdata,   // [63:0] difficulty_bits
  // Result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dttd_pkg::WORD_OUT_W-1:0]     out_tdata,  // [31:0] target_word
  output logic [dttd_pkg::WIDX_W+dttd_pkg::CODE_W-1:0] out_tuser, // [2:0] word_index,
                                                                 // [4:3] clamp_code
  output logic                                out_tlast,  // last_word
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dttd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dttd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dttd_pkg::cfg_t                   cfg;
  dttd_pkg::cmd_t                   cmd;
  logic [dttd_pkg::WIDX_W-1:0]      word_idx;
  logic [dttd_pkg::CODE_W-1:0]      clamp_code;

  dttd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dttd_ctrl #(
    .TARGET_BITS (TARGET_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .word_idx   (word_idx),
    .cmd        (cmd)
  );

  dttd_datapath #(
    .TARGET_BITS (TARGET_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .in_tdata   (in_tdata),
    .cfg        (cfg),
    .cmd        (cmd),
    .tgt_word   (out_tdata),
    .clamp_code (clamp_code)
  );

  // Pack word position low, clamp code above it
  assign out_tuser = {clamp_code, word_idx};

endmodule

FILE: sv/dttd_cfg_regs.sv
// Configuration register file of the difficulty-to-target divider.
module dttd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dttd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dttd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output dttd_pkg::cfg_t                      cfg
);

  dttd_pkg::cfg_t cfg_r;

  // Always take a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Store the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_mant  <= dttd_pkg::REF_MANT_RST;
      cfg_r.ref_shift <= dttd_pkg::REF_SHIFT_RST;
      cfg_r.max_mant  <= dttd_pkg::MAX_MANT_RST;
      cfg_r.max_shift <= dttd_pkg::MAX_SHIFT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dttd_pkg::REG_REF_MANT: begin
          cfg_r.ref_mant <= cfg_data[dttd_pkg::REF_MANT_W-1:0];
        end
        dttd_pkg::REG_REF_SHIFT: begin
          cfg_r.ref_shift <= cfg_data[dttd_pkg::SHIFT_W-1:0];
        end
        dttd_pkg::REG_MAX_MANT: begin
          cfg_r.max_mant <= cfg_data[dttd_pkg::REF_MANT_W-1:0];
        end
        dttd_pkg::REG_MAX_SHIFT: begin
          cfg_r.max_shift <= cfg_data[dttd_pkg::SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/dttd_ctrl.sv
// Sequencer of the difficulty-to-target divider: division steps and word emission.
module dttd_ctrl #(
  parameter int TARGET_BITS = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tlast,
  output logic [dttd_pkg::WIDX_W-1:0]     word_idx,
  output dttd_pkg::cmd_t                  cmd
);

  localparam int NWORDS_RAW = TARGET_BITS / WORD_BITS;
  localparam int NWORDS     = (NWORDS_RAW > dttd_pkg::MAX_WORDS) ? dttd_pkg::MAX_WORDS
                                                                  : NWORDS_RAW;

  dttd_pkg::state_t                state_r, state_nxt;
  logic [dttd_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            emit_r, emit_nxt;
  logic [dttd_pkg::WIDX_W-1:0]     word_r, word_nxt;
  logic                            word_last;

  assign word_last  = (word_r == dttd_pkg::WIDX_W'(NWORDS - 1));
  assign out_tvalid = emit_r;
  assign out_tlast  = word_last;
  assign word_idx   = word_r;

  // Hold state, counters and emitter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dttd_pkg::ST_IDLE;
      cnt_r   <= '0;
      emit_r  <= 1'b0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
      word_r  <= word_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    word_nxt  = word_r;
    cmd       = '0;
    in_tready = 1'b0;

    // Advance the emitter on each taken word
    if (emit_r && out_tready) begin
      cmd.shift_out = 1'b1;
      if (word_last) begin
        emit_nxt = 1'b0;
        word_nxt = '0;
      end else begin
        word_nxt = word_r + 1'b1;
      end
    end

    unique case (state_r)
      dttd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = dttd_pkg::CNT_W'(dttd_pkg::DIV_TOP);
          state_nxt = dttd_pkg::ST_DIVIDE;
        end
      end
      dttd_pkg::ST_DIVIDE: begin
        cmd.step   = 1'b1;
        cmd.hi_pos = (cnt_r >= dttd_pkg::CNT_W'(dttd_pkg::QUOT_BITS));
        if (cnt_r == '0) begin
          state_nxt = dttd_pkg::ST_RESOLVE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      dttd_pkg::ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = dttd_pkg::ST_FINISH;
      end
      dttd_pkg::ST_FINISH: begin
        // Wait until the previous target has left the output register
        if (!emit_r) begin
          cmd.finish = 1'b1;
          emit_nxt   = 1'b1;
          word_nxt   = '0;
          state_nxt  = dttd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dttd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/dttd_datapath.sv
// Datapath of the difficulty-to-target divider: decode, restoring divider, clamp, output word.
module dttd_datapath #(
  parameter int TARGET_BITS = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                                clk,
  input  logic [dttd_pkg::DIFF_W-1:0]         in_tdata,
  input  dttd_pkg::cfg_t                      cfg,
  input  dttd_pkg::cmd_t                      cmd,
  output logic [dttd_pkg::WORD_OUT_W-1:0]     tgt_word,
  output logic [dttd_pkg::CODE_W-1:0]         clamp_code
);

  localparam int QB = dttd_pkg::QUOT_BITS;
  localparam int SW = dttd_pkg::SIG_W;
  localparam int IW = dttd_pkg::IDX_W;

  // Decoded item
  logic [SW-1:0]                  m_r;
  logic [IW-1:0]                  idx_r;
  dttd_pkg::kind_t                kind_r;
  logic                           big_r;
  // Divider
  logic [SW-1:0]                  rem_r;
  logic [QB-1:0]                  q_r;
  // Clamp and result
  logic [QB-1:0]                  clamp_r;
  logic [QB-1:0]                  sel_r;
  dttd_pkg::clamp_code_t          code_r;
  logic [TARGET_BITS-1:0]         tgt_r;
  dttd_pkg::clamp_code_t          out_code_r;

  logic                           sign;
  logic [dttd_pkg::EXP_W-1:0]     expo;
  logic [dttd_pkg::EXP_W-1:0]     expo_eff;
  logic [dttd_pkg::FRAC_W-1:0]    frac;
  logic [IW-1:0]                  idx_init;
  logic                           big_init;
  dttd_pkg::kind_t                kind_in;
  logic                           idx_in_range;
  logic                           div_bit;
  logic [SW:0]                    rem_sh;
  logic [SW:0]                    rem_diff;
  logic                           qbit;
  logic [SW-1:0]                  rem_step;
  logic                           over;
  logic                           sel_zero;
  logic                           sat;

  // Decode the binary64 word into class, integer significand and start index
  always_comb begin
    sign     = in_tdata[dttd_pkg::DIFF_W-1];
    expo     = in_tdata[dttd_pkg::DIFF_W-2:dttd_pkg::FRAC_W];
    frac     = in_tdata[dttd_pkg::FRAC_W-1:0];
    // Subnormals share the exponent of the smallest normal
    expo_eff = (expo == '0) ? dttd_pkg::EXP_W'(1) : expo;
    idx_init = IW'(expo_eff) + IW'(dttd_pkg::DIV_TOP) - IW'(dttd_pkg::EXP_BIAS_INT)
             - IW'(cfg.ref_shift);
    big_init = (cfg.ref_mant != '0) &&
               (idx_init[IW-1] || (idx_init[IW-2:0] <= (IW-1)'(dttd_pkg::BIG_IDX_MAX)));
    priority if (sign || (expo == '0 && frac == '0) ||
                 (expo == dttd_pkg::EXP_ALL_ONES && frac != '0)) begin
      kind_in = dttd_pkg::KIND_INPUT;
    end else if (expo == dttd_pkg::EXP_ALL_ONES) begin
      kind_in = dttd_pkg::KIND_INF;
    end else begin
      kind_in = dttd_pkg::KIND_FINITE;
    end
  end

  // One restoring division step: bring down a dividend bit, try the subtract
  always_comb begin
    idx_in_range = !idx_r[IW-1] &&
                   (idx_r[IW-2:0] < (IW-1)'(dttd_pkg::REF_MANT_W));
    div_bit  = idx_in_range ? cfg.ref_mant[idx_r[dttd_pkg::MANT_IDX_W-1:0]] : 1'b0;
    rem_sh   = {rem_r, div_bit};
    rem_diff = rem_sh - {1'b0, m_r};
    qbit     = (rem_sh >= {1'b0, m_r});
    rem_step = qbit ? rem_diff[SW-1:0] : rem_sh[SW-1:0];
  end

  // Clamp decision and final fixups
  assign over     = big_r || (q_r > clamp_r);
  assign sel_zero = (kind_r == dttd_pkg::KIND_FINITE) && (sel_r == '0);
  assign sat      = ((sel_r >> TARGET_BITS) != '0);

  // Present the low word of the target
  assign tgt_word   = dttd_pkg::WORD_OUT_W'(tgt_r[WORD_BITS-1:0]);
  assign clamp_code = out_code_r;

  // Track the clamp target from the registers
  always_ff @(posedge clk) begin
    clamp_r <= QB'(cfg.max_mant) << cfg.max_shift;
  end

  // Load the item, then iterate the divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= {expo != '0, frac};
      idx_r  <= idx_init;
      kind_r <= kind_in;
      big_r  <= big_init;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r - 1'b1;
      rem_r <= rem_step;
      q_r   <= {q_r[QB-2:0], qbit};
      if (cmd.hi_pos && qbit) begin
        big_r <= 1'b1;
      end
    end
  end

  // Pick quotient or clamp by class
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      unique case (kind_r)
        dttd_pkg::KIND_FINITE: begin
          sel_r  <= over ? clamp_r : q_r;
          code_r <= over ? dttd_pkg::CLAMP_MAX : dttd_pkg::CLAMP_NONE;
        end
        dttd_pkg::KIND_INF: begin
          sel_r  <= QB'(1);
          code_r <= dttd_pkg::CLAMP_ONE;
        end
        default: begin
          sel_r  <= clamp_r;
          code_r <= dttd_pkg::CLAMP_INPUT;
        end
      endcase
    end
  end

  // Raise zero to one, saturate, load the output register; shift out words
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sat) begin
        tgt_r      <= '1;
        out_code_r <= (kind_r == dttd_pkg::KIND_INPUT) ? dttd_pkg::CLAMP_INPUT
                                                       : dttd_pkg::CLAMP_MAX;
      end else if (sel_zero) begin
        tgt_r      <= TARGET_BITS'(1);
        out_code_r <= dttd_pkg::CLAMP_ONE;
      end else begin
        tgt_r      <= TARGET_BITS'(sel_r);
        out_code_r <= code_r;
      end
    end else if (cmd.shift_out) begin
      tgt_r <= tgt_r >> WORD_BITS;
    end
  end

endmodule

FILE: tb/target_word_checker.sv
// Watches the divider's channels, predicts every target word and compares it with what leaves.
`timescale 1ns / 1ps

module target_word_checker
  import dttd_pkg::*;
#(
  parameter int TARGET_BITS = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [DIFF_W-1:0]             in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [WORD_OUT_W-1:0]         out_tdata,
  input  logic [WIDX_W+CODE_W-1:0]      out_tuser,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output int                            mismatches,
  output int                            words_due
);

  localparam int NUM_WORDS = TARGET_BITS / WORD_BITS;
  // Wide enough for the largest reference shifted up by the smallest subnormal exponent
  localparam int DIV_W     = 1408;

  typedef struct packed {
    logic [WORD_OUT_W-1:0] word;
    logic [WIDX_W-1:0]     pos;
    logic                  last;
    clamp_code_t           code;
  } target_word_t;

  cfg_t         regs;
  target_word_t target_words_due[$];

  // Exact floor(reference / difficulty) with the clamp, raise-to-one and saturation rules
  function automatic void divide_difficulty(input logic [DIFF_W-1:0] bits,
                                            output logic [TARGET_BITS-1:0] target,
                                            output clamp_code_t code);
    logic [EXP_W-1:0]  expo;
    logic [FRAC_W-1:0] frac;
    logic [SIG_W-1:0]  sig;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  quo;
    logic [DIV_W-1:0]  lim;
    int                e;
    expo = bits[DIFF_W-2 -: EXP_W];
    frac = bits[FRAC_W-1:0];
    lim  = DIV_W'(regs.max_mant) << regs.max_shift;
    if (bits[DIFF_W-1] || (expo == '0 && frac == '0) ||
        (expo == EXP_ALL_ONES && frac != '0)) begin
      // negative, zero or NaN: clamp target, never raised to one
      quo  = lim;
      code = CLAMP_INPUT;
    end else if (expo == EXP_ALL_ONES) begin
      quo  = DIV_W'(1);
      code = CLAMP_ONE;
    end else begin
      sig  = (expo == '0) ? {1'b0, frac} : {1'b1, frac};
      e    = (expo == '0) ? 1 - EXP_BIAS_INT : int'(expo) - EXP_BIAS_INT;
      num  = DIV_W'(regs.ref_mant) << regs.ref_shift;
      // floor(floor(x / 2^e) / m) equals floor(x / (m * 2^e))
      if (e < 0) num = num << (-e);
      else       num = num >> e;
      quo  = num / DIV_W'(sig);
      code = CLAMP_NONE;
      if (quo > lim) begin
        quo  = lim;
        code = CLAMP_MAX;
      end
      if (quo == '0) begin
        quo  = DIV_W'(1);
        code = CLAMP_ONE;
      end
    end
    // saturate to all ones above the target width
    if (|quo[DIV_W-1:TARGET_BITS]) begin
      quo = {{(DIV_W-TARGET_BITS){1'b0}}, {TARGET_BITS{1'b1}}};
      if (code != CLAMP_INPUT) code = CLAMP_MAX;
    end
    target = quo[TARGET_BITS-1:0];
  endfunction

  task automatic flag_word(input string field, input logic [WORD_OUT_W-1:0] want,
                           input logic [WORD_OUT_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    target_word_t           due;
    logic [TARGET_BITS-1:0] target;
    clamp_code_t            code;
    if (!rst_n) begin
      regs <= '{ref_mant: REF_MANT_RST, ref_shift: REF_SHIFT_RST,
                max_mant: MAX_MANT_RST, max_shift: MAX_SHIFT_RST};
      target_words_due.delete();
      mismatches = 0;
    end else begin
      // track register writes, drop unknown indexes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REF_MANT:  regs.ref_mant  <= cfg_data[REF_MANT_W-1:0];
          REG_REF_SHIFT: regs.ref_shift <= cfg_data[SHIFT_W-1:0];
          REG_MAX_MANT:  regs.max_mant  <= cfg_data[REF_MANT_W-1:0];
          REG_MAX_SHIFT: regs.max_shift <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // queue the words of each accepted difficulty
      if (in_tvalid && in_tready) begin
        divide_difficulty(in_tdata, target, code);
        for (int k = 0; k < NUM_WORDS; k++)
          target_words_due.push_back('{word: target[k*WORD_BITS +: WORD_BITS],
                                       pos:  WIDX_W'(k),
                                       last: (k == NUM_WORDS - 1),
                                       code: code});
      end
      // compare each word that leaves against the oldest one due
      if (out_tvalid && out_tready) begin
        if (target_words_due.size() == 0) begin
          flag_word("unexpected word", '0, out_tdata);
        end else begin
          due = target_words_due.pop_front();
          if (out_tdata != due.word)
            flag_word("target_word", due.word, out_tdata);
          if (out_tuser[WIDX_W-1:0] != due.pos)
            flag_word("word_index", WORD_OUT_W'(due.pos), WORD_OUT_W'(out_tuser[WIDX_W-1:0]));
          if (out_tlast != due.last)
            flag_word("last_word", WORD_OUT_W'(due.last), WORD_OUT_W'(out_tlast));
          if (out_tuser[WIDX_W +: CODE_W] != due.code)
            flag_word("clamp_code", WORD_OUT_W'(due.code),
                      WORD_OUT_W'(out_tuser[WIDX_W +: CODE_W]));
        end
      end
    end
    words_due <= target_words_due.size();
  end

endmodule

FILE: tb/tb_difficulty_to_target_divider_core.sv
// Stimulus and verdict for the difficulty-to-target divider, checked by target_word_checker.
`timescale 1ns / 1ps

module tb_difficulty_to_target_divider_core;
  import dttd_pkg::*;

  // Register indexes the block must ignore
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 8'hff;
  localparam int ITEMS_PER_MODE = 21;
  localparam int NUM_MODES      = 4;
  localparam int DRAIN_CYCLES   = 400;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic [DIFF_W-1:0]            in_tdata  = '0;
  logic                         out_tready = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;
  logic                         in_tready;
  logic                         out_tvalid;
  logic [WORD_OUT_W-1:0]        out_tdata;
  logic [WIDX_W+CODE_W-1:0]     out_tuser;
  logic                         out_tlast;
  logic                         cfg_ready;
  int                           mismatches;
  int                           words_due;

  int                           gap_pct   = 0;
  int                           stall_pct = 0;
  int                           gap_modes[NUM_MODES]   = '{0, 59, 0, 34};
  int                           stall_modes[NUM_MODES] = '{0, 0, 59, 34};
  logic [SHIFT_W-1:0]           ref_shift_now = REF_SHIFT_RST;
  logic [SHIFT_W-1:0]           max_shift_now = MAX_SHIFT_RST;

  // Edge cases of the binary64 encoding, run under the reset registers
  logic [DIFF_W-1:0] corner_diffs[22] = '{
    64'h3FF0000000000000,  // 1.0
    64'h4000000000000000,  // 2.0
    64'h3FE0000000000000,  // 0.5
    64'h4008000000000000,  // 3.0
    64'h3FEFFFFFFFFFFFFF,  // just below one
    64'h41EFFFFFFFFFFFFF,  // full fraction, mid exponent
    64'h3EB0000000000000,  // 2^-20, above the clamp
    64'h0000000000000001,  // smallest subnormal, quotient overflows
    64'h000FFFFFFFFFFFFF,  // largest subnormal
    64'h0010000000000000,  // smallest normal
    64'h7FEFFFFFFFFFFFFF,  // largest finite, raised to one
    64'h52B0000000000000,  // 2^300, raised to one
    64'h4CF0000000000000,  // 2^208, quotient equals the reference mantissa
    64'h4E20000000000000,  // 2^227, quotient one
    64'h4E30000000000000,  // 2^228, quotient zero
    64'h7FF0000000000000,  // +inf
    64'hFFF0000000000000,  // -inf
    64'h0000000000000000,  // +0
    64'h8000000000000000,  // -0
    64'h7FF8000000000000,  // quiet NaN
    64'h7FF0000000000001,  // signaling NaN
    64'hFFFFFFFFFFFFFFFF   // negative NaN
  };

  always #2 clk = ~clk;

  // Receiver stalls at the rate of the current mode
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  difficulty_to_target_divider_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [63:0] difficulty_bits
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] target_word
    .out_tuser  (out_tuser),   // [2:0] word_index, [4:3] clamp_code
    .out_tlast  (out_tlast),   // last_word
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  target_word_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  // Mostly difficulties whose quotient lands between one and the clamp, plus noise
  function automatic logic [DIFF_W-1:0] random_difficulty();
    int                pick;
    int                e_int;
    logic              sign;
    logic [EXP_W-1:0]  expo;
    logic [FRAC_W-1:0] frac;
    pick = $urandom_range(99);
    sign = 1'b0;
    frac = FRAC_W'({$urandom, $urandom});
    if (pick < 60) begin
      e_int = 1023 + int'(ref_shift_now) - int'(max_shift_now) - 8
              + $urandom_range(int'(max_shift_now) + 40);
      if (e_int < 1) e_int = 1;
      if (e_int > 2046) e_int = 2046;
      expo = EXP_W'(e_int);
      if ($urandom_range(7) == 0) frac = '0;
    end else if (pick < 70) begin
      expo = EXP_W'($urandom_range(2046, 1));
    end else if (pick < 78) begin
      expo = '0;
      frac = frac >> $urandom_range(51);
    end else if (pick < 88) begin
      {sign, expo, frac} = {$urandom, $urandom};
    end else begin
      case ($urandom_range(5))
        0: begin expo = EXP_ALL_ONES; frac = '0; end
        1: begin sign = 1'b1; expo = EXP_ALL_ONES; frac = '0; end
        2: begin expo = '0; frac = '0; end
        3: begin sign = 1'b1; expo = '0; frac = '0; end
        4: begin sign = 1'($urandom); expo = EXP_ALL_ONES; frac = frac | FRAC_W'(1); end
        default: begin sign = 1'b1; expo = EXP_W'($urandom_range(2046)); end
      endcase
    end
    return {sign, expo, frac};
  endfunction

  // Present one word, with random gaps before it, and hold until taken
  task automatic send_difficulty(input logic [DIFF_W-1:0] bits);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted word has left
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers, junk in the unused bits and at unused indexes, then run every gap and stall mode
  task automatic run_phase(input logic [REF_MANT_W-1:0] ref_mant,
                           input logic [SHIFT_W-1:0] ref_shift,
                           input logic [REF_MANT_W-1:0] max_mant,
                           input logic [SHIFT_W-1:0] max_shift);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_REF_MANT, ref_mant);
    write_reg(REG_REF_SHIFT, {16'($urandom), ref_shift});
    write_reg(REG_MAX_MANT, max_mant);
    write_reg(REG_MAX_SHIFT, {16'($urandom), max_shift});
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid     <= 1'b0;
    ref_shift_now = ref_shift;
    max_shift_now = max_shift;
    for (int m = 0; m < NUM_MODES; m++) begin
      gap_pct   = gap_modes[m];
      stall_pct = stall_modes[m];
      repeat (ITEMS_PER_MODE) send_difficulty(random_difficulty());
    end
    drain();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under the reset registers, no idling
    foreach (corner_diffs[i]) send_difficulty(corner_diffs[i]);
    drain();

    // register settings: all high, all zero, zero clamp, random, tight clamp, reset values
    run_phase('1, '1, '1, '1);
    run_phase('0, '0, '0, '0);
    run_phase(REF_MANT_RST, REF_SHIFT_RST, '0, SHIFT_W'($urandom));
    run_phase(REF_MANT_W'($urandom), SHIFT_W'($urandom), REF_MANT_W'($urandom),
              SHIFT_W'($urandom));
    run_phase(REF_MANT_RST, REF_SHIFT_RST, 24'h00ffff, MAX_SHIFT_RST);
    run_phase(REF_MANT_RST, REF_SHIFT_RST, MAX_MANT_RST, MAX_SHIFT_RST);

    // let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
